// File: src/assert_macros.svh
// Assertion macros shared by the line history ring buffer RTL.
// No dependencies; define SYNTH to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check under reset qualification.
`define LHRB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("lhrb assertion failed");
// Check that also runs while reset is held.
`define LHRB_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("lhrb assertion failed");
`else
`define LHRB_ASSERT(lbl, clk, rst_n, prop)
`define LHRB_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// File: src/lhrb_pkg.sv
// Shared constants and controller/datapath interface types for the line history ring buffer.
// No dependencies.
`default_nettype none
package lhrb_pkg;

    localparam int RING_BYTES_DEF = 64;

    // input command codes
    localparam logic [1:0] CMD_SAVE  = 2'd0;
    localparam logic [1:0] CMD_OLDER = 2'd1;
    localparam logic [1:0] CMD_NEWER = 2'd2;

    // result status codes
    localparam logic [1:0] ST_CHAR   = 2'd0;
    localparam logic [1:0] ST_NEWEST = 2'd1;
    localparam logic [1:0] ST_OLDEST = 2'd2;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_HEAD_LEN,
        WR_TAIL_LEN,
        WR_TAIL_STG,
        WR_TAIL_ZERO
    } t_wsel;

    typedef enum logic [1:0] {
        LIM_RB,
        LIM_OLD,
        LIM_NEW
    } t_lim;

    typedef enum logic [1:0] {
        DEP_KEEP,
        DEP_INC,
        DEP_DEC,
        DEP_CLR
    } t_dop;

    typedef enum logic [1:0] {
        OK_CHAR,
        OK_NEWEST,
        OK_OLDEST
    } t_okind;

    typedef struct packed {
        logic   stage_wr;
        logic   walk_init;
        t_lim   lim_sel;
        logic   t_load;
        logic   t_inc;
        logic   walk_step;
        logic   sum_step;
        logic   room_chk;
        logic   len_load;
        logic   out_load;
        t_okind out_kind;
        t_wsel  ring_wr;
        logic   idx_clr;
        logic   idx_inc;
        logic   oldest_load;
        logic   wptr_load;
        t_dop   depth_op;
    } t_cmd;

    typedef struct packed {
        logic walk_stop;
        logic sum_ge;
        logic old_ok;
        logic new_ok;
        logic depth_zero;
        logic commit_go;
        logic emit_last;
        logic copy_done;
        logic clr_last;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

// File: src/lhrb_ram.sv
// Generic single write port RAM with registered read data.
// No dependencies.
`default_nettype none
module lhrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: src/lhrb_ctrl.sv
// Sequencer for the line history ring buffer: walks, commit, recall and emit steps.
// Depends on lhrb_pkg.
`default_nettype none
module lhrb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_command,
    input  lhrb_pkg::t_sts i_sts,
    output lhrb_pkg::t_cmd o_cmd,
    output logic          o_in_stall
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_WRD, S_WEV, S_WMOD, S_DOLD, S_DNEW, S_ELEN,
        S_ERD, S_EOUT, S_STAT, S_CHEAD, S_CTAIL, S_CPRD, S_CPWR, S_CFIN
    } t_state;

    typedef enum logic [1:0] {
        M_CNT_OLD, M_CNT_NEW, M_LOCATE, M_COMMIT
    } t_mode;

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;
    lhrb_pkg::t_okind r_code, n_code;
    lhrb_pkg::t_cmd   cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        n_mode  = r_mode;
        n_code  = r_code;
        unique case (r_state)
            S_CLEAR: begin
                cmd.ring_wr = lhrb_pkg::WR_TAIL_ZERO;
                cmd.t_inc   = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_command)
                        lhrb_pkg::CMD_SAVE: begin
                            cmd.stage_wr = 1'b1;
                            if (i_sts.commit_go) begin
                                cmd.walk_init = 1'b1;
                                cmd.lim_sel   = lhrb_pkg::LIM_RB;
                                cmd.t_load    = 1'b1;
                                n_mode        = M_COMMIT;
                                n_state       = S_WRD;
                            end
                        end
                        lhrb_pkg::CMD_OLDER: begin
                            cmd.walk_init = 1'b1;
                            cmd.lim_sel   = lhrb_pkg::LIM_RB;
                            n_mode        = M_CNT_OLD;
                            n_state       = S_WRD;
                        end
                        lhrb_pkg::CMD_NEWER: begin
                            if (i_sts.depth_zero) begin
                                n_code  = lhrb_pkg::OK_NEWEST;
                                n_state = S_STAT;
                            end else begin
                                cmd.walk_init = 1'b1;
                                cmd.lim_sel   = lhrb_pkg::LIM_RB;
                                n_mode        = M_CNT_NEW;
                                n_state       = S_WRD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WRD: n_state = S_WEV;
            S_WEV: begin
                cmd.room_chk = (r_mode == M_COMMIT);
                if (i_sts.walk_stop) begin
                    unique case (r_mode)
                        M_CNT_OLD: n_state = S_DOLD;
                        M_CNT_NEW: n_state = S_DNEW;
                        M_LOCATE:  n_state = S_ELEN;
                        M_COMMIT:  n_state = S_CHEAD;
                        default:   n_state = S_IDLE;
                    endcase
                end else begin
                    cmd.walk_step = 1'b1;
                    n_state       = S_WMOD;
                end
            end
            S_WMOD: begin
                cmd.sum_step = 1'b1;
                if (!i_sts.sum_ge) begin
                    n_state = S_WRD;
                end
            end
            S_DOLD: begin
                if (i_sts.old_ok) begin
                    cmd.walk_init = 1'b1;
                    cmd.lim_sel   = lhrb_pkg::LIM_OLD;
                    cmd.depth_op  = lhrb_pkg::DEP_INC;
                    n_mode        = M_LOCATE;
                    n_state       = S_WRD;
                end else begin
                    n_code  = lhrb_pkg::OK_OLDEST;
                    n_state = S_STAT;
                end
            end
            S_DNEW: begin
                cmd.depth_op = lhrb_pkg::DEP_DEC;
                if (i_sts.new_ok) begin
                    cmd.walk_init = 1'b1;
                    cmd.lim_sel   = lhrb_pkg::LIM_NEW;
                    n_mode        = M_LOCATE;
                    n_state       = S_WRD;
                end else begin
                    n_code  = lhrb_pkg::OK_NEWEST;
                    n_state = S_STAT;
                end
            end
            S_ELEN: begin
                cmd.len_load = 1'b1;
                n_state      = S_ERD;
            end
            S_ERD: n_state = S_EOUT;
            S_EOUT: begin
                if (i_sts.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = lhrb_pkg::OK_CHAR;
                    n_state      = i_sts.emit_last ? S_IDLE : S_ERD;
                end
            end
            S_STAT: begin
                if (i_sts.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = r_code;
                    n_state      = S_IDLE;
                end
            end
            S_CHEAD: begin
                cmd.ring_wr     = lhrb_pkg::WR_HEAD_LEN;
                cmd.oldest_load = 1'b1;
                n_state         = S_CTAIL;
            end
            S_CTAIL: begin
                cmd.ring_wr = lhrb_pkg::WR_TAIL_LEN;
                cmd.t_inc   = 1'b1;
                cmd.idx_clr = 1'b1;
                n_state     = S_CPRD;
            end
            S_CPRD: n_state = i_sts.copy_done ? S_CFIN : S_CPWR;
            S_CPWR: begin
                cmd.ring_wr = lhrb_pkg::WR_TAIL_STG;
                cmd.t_inc   = 1'b1;
                cmd.idx_inc = 1'b1;
                n_state     = S_CPRD;
            end
            S_CFIN: begin
                cmd.ring_wr   = lhrb_pkg::WR_TAIL_ZERO;
                cmd.wptr_load = 1'b1;
                cmd.depth_op  = lhrb_pkg::DEP_CLR;
                n_state       = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_mode  <= M_CNT_OLD;
            r_code  <= lhrb_pkg::OK_CHAR;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_code  <= n_code;
        end
    end

    assign o_cmd      = cmd;
    assign o_in_stall = (r_state != S_IDLE);

endmodule
`default_nettype wire

// File: src/lhrb_dp.sv
// Datapath of the line history ring buffer: pointers, counters, ring and staging RAMs,
// output register. Depends on lhrb_pkg and lhrb_ram.
`default_nettype none
module lhrb_dp #(
    parameter int RING_BYTES = lhrb_pkg::RING_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lhrb_pkg::t_cmd i_cmd,
    output lhrb_pkg::t_sts o_sts,
    input  logic [7:0]     i_char_byte,
    input  logic           i_last_byte,
    input  logic           i_out_stall,
    output logic           o_out_valid,
    output logic [1:0]     o_status,
    output logic [7:0]     o_char_byte_res,
    output logic [5:0]     o_line_length,
    output logic           o_last_item
);

    localparam int LineLimit = RING_BYTES - 2;
    localparam int PW  = $clog2(RING_BYTES);
    localparam int CW  = $clog2(RING_BYTES + 1);
    localparam int CW1 = CW + 1;
    localparam int SW  = $clog2(RING_BYTES + 256);
    localparam int RW  = PW + 2;
    localparam int SAW = $clog2(LineLimit);

    logic [PW-1:0] r_p, r_t, r_oldest, r_wptr;
    logic [SW-1:0] r_sum;
    logic [CW-1:0] r_n, r_lim, r_len, r_idx, r_depth, r_scount;
    logic          r_out_valid, r_last;
    logic [1:0]    r_status;
    logic [7:0]    r_char;
    logic [5:0]    r_llen;

    logic [7:0]    ring_q, stg_q, ring_wdata;
    logic [PW-1:0] ring_waddr, p_next, t_next;
    logic          ring_we, stg_we, sum_ge, out_free, commit_go;
    logic [CW-1:0] n_cnt, lim_old, lim_new, len_clip;
    logic [RW-1:0] h_x, t_x, room;

    lhrb_ram #(.WIDTH(8), .DEPTH(RING_BYTES)) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (ring_waddr),
        .i_wdata (ring_wdata),
        .i_raddr (r_p),
        .o_rdata (ring_q)
    );

    lhrb_ram #(.WIDTH(8), .DEPTH(LineLimit)) u_stage (
        .i_clk   (i_clk),
        .i_we    (stg_we),
        .i_waddr (r_scount[SAW-1:0]),
        .i_wdata (i_char_byte),
        .i_raddr (r_idx[SAW-1:0]),
        .o_rdata (stg_q)
    );

    assign stg_we   = i_cmd.stage_wr && (r_scount < CW'(LineLimit));
    assign n_cnt    = (r_scount < CW'(LineLimit + 1)) ? r_scount + CW'(1) : r_scount;
    assign commit_go = i_last_byte && (n_cnt != '0) && (n_cnt <= CW'(LineLimit));

    assign p_next = (r_p == PW'(RING_BYTES - 1)) ? '0 : r_p + PW'(1);
    assign t_next = (r_t == PW'(RING_BYTES - 1)) ? '0 : r_t + PW'(1);

    // free bytes between write end and candidate oldest record
    assign h_x  = RW'(r_p);
    assign t_x  = RW'(r_wptr);
    assign room = (t_x < h_x) ? h_x - t_x - RW'(1) : RW'(RING_BYTES) + h_x - t_x - RW'(1);

    assign sum_ge   = (r_sum >= SW'(RING_BYTES));
    assign out_free = !r_out_valid || !i_out_stall;
    assign lim_old  = r_n - r_depth - CW'(1);
    assign lim_new  = CW'(CW1'(r_n) + CW1'(1) - CW1'(r_depth));
    assign len_clip = (ring_q > 8'(LineLimit)) ? CW'(LineLimit) : CW'(ring_q);

    always_comb begin
        o_sts.walk_stop  = (ring_q == 8'd0) || (r_n == r_lim)
                         || (i_cmd.room_chk && (RW'(r_len) < room));
        o_sts.sum_ge     = sum_ge;
        o_sts.old_ok     = (r_depth < r_n);
        o_sts.new_ok     = (r_depth >= CW'(2)) && (CW1'(r_depth) <= CW1'(r_n) + CW1'(1));
        o_sts.depth_zero = (r_depth == '0);
        o_sts.commit_go  = commit_go;
        o_sts.emit_last  = (CW1'(r_idx) + CW1'(1)) == CW1'(r_len);
        o_sts.copy_done  = (r_idx == r_len);
        o_sts.clr_last   = (r_t == PW'(RING_BYTES - 1));
        o_sts.out_free   = out_free;
    end

    always_comb begin
        ring_we    = 1'b0;
        ring_waddr = r_t;
        ring_wdata = 8'd0;
        unique case (i_cmd.ring_wr)
            lhrb_pkg::WR_NONE: ring_we = 1'b0;
            lhrb_pkg::WR_HEAD_LEN: begin
                // empty head slot takes the new length
                ring_we    = (ring_q == 8'd0);
                ring_waddr = r_p;
                ring_wdata = 8'(r_len);
            end
            lhrb_pkg::WR_TAIL_LEN: begin
                ring_we    = 1'b1;
                ring_wdata = 8'(r_len);
            end
            lhrb_pkg::WR_TAIL_STG: begin
                ring_we    = 1'b1;
                ring_wdata = stg_q;
            end
            lhrb_pkg::WR_TAIL_ZERO: ring_we = 1'b1;
            default: ring_we = 1'b0;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest    <= '0;
            r_wptr      <= '0;
            r_t         <= '0;
            r_depth     <= '0;
            r_scount    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.stage_wr) begin
                r_scount <= i_last_byte ? '0 : n_cnt;
            end
            if (i_cmd.t_load) begin
                r_t <= r_wptr;
            end else if (i_cmd.t_inc) begin
                r_t <= t_next;
            end
            if (i_cmd.oldest_load) begin
                r_oldest <= r_p;
            end
            if (i_cmd.wptr_load) begin
                r_wptr <= r_t;
            end
            case (i_cmd.depth_op)
                lhrb_pkg::DEP_INC: r_depth <= r_depth + CW'(1);
                lhrb_pkg::DEP_DEC: r_depth <= r_depth - CW'(1);
                lhrb_pkg::DEP_CLR: r_depth <= '0;
                default:           r_depth <= r_depth;
            endcase
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // walk and emit payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_init) begin
            r_p <= r_oldest;
        end else if (i_cmd.sum_step && !sum_ge) begin
            r_p <= r_sum[PW-1:0];
        end else if (i_cmd.len_load
                     || (i_cmd.out_load && i_cmd.out_kind == lhrb_pkg::OK_CHAR)) begin
            r_p <= p_next;
        end

        if (i_cmd.walk_init) begin
            r_n <= '0;
            case (i_cmd.lim_sel)
                lhrb_pkg::LIM_OLD: r_lim <= lim_old;
                lhrb_pkg::LIM_NEW: r_lim <= lim_new;
                default:           r_lim <= CW'(RING_BYTES);
            endcase
        end else if (i_cmd.walk_step) begin
            r_n <= r_n + CW'(1);
        end

        // next record offset, reduced below the ring size by repeated subtraction
        if (i_cmd.walk_step) begin
            r_sum <= SW'(r_p) + SW'(ring_q) + SW'(1);
        end else if (i_cmd.sum_step && sum_ge) begin
            r_sum <= r_sum - SW'(RING_BYTES);
        end

        if (i_cmd.stage_wr && commit_go) begin
            r_len <= n_cnt;
        end else if (i_cmd.len_load) begin
            r_len <= len_clip;
        end

        if (i_cmd.len_load || i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc
                     || (i_cmd.out_load && i_cmd.out_kind == lhrb_pkg::OK_CHAR)) begin
            r_idx <= r_idx + CW'(1);
        end

        if (i_cmd.out_load) begin
            case (i_cmd.out_kind)
                lhrb_pkg::OK_CHAR: begin
                    r_status <= lhrb_pkg::ST_CHAR;
                    r_char   <= ring_q;
                    r_llen   <= 6'(r_len);
                    r_last   <= o_sts.emit_last;
                end
                lhrb_pkg::OK_NEWEST: begin
                    r_status <= lhrb_pkg::ST_NEWEST;
                    r_char   <= 8'd0;
                    r_llen   <= 6'd0;
                    r_last   <= 1'b1;
                end
                default: begin
                    r_status <= lhrb_pkg::ST_OLDEST;
                    r_char   <= 8'd0;
                    r_llen   <= 6'd0;
                    r_last   <= 1'b1;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_char_byte_res = r_char;
    assign o_line_length   = r_llen;
    assign o_last_item     = r_last;

endmodule
`default_nettype wire

// File: src/line_history_ring_buffer_top.sv
// Line history ring buffer: top level joining the sequencer and the datapath.
// Depends on lhrb_pkg, lhrb_ctrl, lhrb_dp (lhrb_ram) and assert_macros.svh.
//
// Input channel (i_in_valid / o_in_stall) carries one transaction per save byte or
// recall command. Output channel (o_out_valid / i_out_stall) carries recalled
// characters, one transaction each, or a single status transaction.
// Save bytes are staged; a last byte commits a line of up to RING_BYTES - 2 bytes
// to the ring, evicting oldest records as needed. Recall older/newer walks them.
// A save byte not ending a line is staged without leaving idle. A commit walks
// the records, then copies the staged line; a record walked is a ring RAM read
// then the modulo step, one cycle per ring length taken off. A recall counts the
// records (no walk for newer at depth zero), then locates the line unless a
// status ends it, and emits each character by a ring read then an output step.
// One transaction is in work at a time; o_in_stall is high while it is.
// The output register frees the sequencer: a finished result may wait while a
// new transaction is accepted; if i_out_stall holds, emission simply pauses.
// Reset: synchronous, active low. Afterwards the ring is cleared one entry per
// cycle with o_in_stall high; staged bytes are discarded.
`default_nettype none
`include "assert_macros.svh"
module line_history_ring_buffer_top #(
    parameter int RING_BYTES = lhrb_pkg::RING_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_command,
    input  logic [7:0] i_char_byte,
    input  logic       i_last_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_status,
    output logic [7:0] o_char_byte_res,
    output logic [5:0] o_line_length,
    output logic       o_last_item
);

    lhrb_pkg::t_cmd cmd;
    lhrb_pkg::t_sts sts;

    // sequencer: decides each step from datapath status
    lhrb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // datapath: ring/staging stores, pointers and output register
    lhrb_dp #(.RING_BYTES(RING_BYTES)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_char_byte     (i_char_byte),
        .i_last_byte     (i_last_byte),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_char_byte_res (o_char_byte_res),
        .o_line_length   (o_line_length),
        .o_last_item     (o_last_item)
    );

    // reset empties the output register
    `LHRB_ASSERT_NR(a_reset_quiet, i_clk, !i_rst_n |=> !o_out_valid)
    // clearing pass follows reset
    `LHRB_ASSERT(a_clear_after_reset, i_clk, i_rst_n, $rose(i_rst_n) |-> o_in_stall)
    // a line still being emitted keeps the input side stalled
    `LHRB_ASSERT(a_emit_blocks_input, i_clk, i_rst_n,
        o_out_valid && !o_last_item |-> o_in_stall)
    // a recall transaction always occupies the sequencer
    `LHRB_ASSERT(a_recall_busy, i_clk, i_rst_n,
        i_in_valid && !o_in_stall && (i_command == lhrb_pkg::CMD_OLDER
            || i_command == lhrb_pkg::CMD_NEWER) |=> o_in_stall)

endmodule
`default_nettype wire
